// ===== src/mbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbpe_pkg
// Shared types and constants of the mask boundary point extractor.
// ----------------------------------------------------------------------------
package mbpe_pkg;

  localparam int MaxWidthDefault  = 1024;
  localparam int MaxHeightDefault = 1024;

  localparam int PixelW   = 32;
  localparam int CoordW   = 10;
  localparam int CfgDataW = 11;
  localparam int CfgIdxW  = 1;

  localparam int AlphaShift = 24;
  localparam int AlphaMask  = 'hFF;

  // Reset value of both size registers
  localparam int CfgSizeReset = 1024;

  // Depth of the queue between classifier and line-buffer stage
  localparam int QueueDepth = 4;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 1'd1;

  // Classification of one pixel, produced by the front end
  typedef struct packed {
    logic              below;     // mask bit of the incoming pixel
    logic              interior;  // decided pixel lies off the border
    logic              last;      // incoming pixel closes the frame
    logic [CoordW-1:0] px;        // column of the decided pixel
    logic [CoordW-1:0] py;        // row of the decided pixel
  } mbpe_cls_t;

endpackage

// ===== src/mbpe_pixel_if.sv =====
// ----------------------------------------------------------------------------
// mbpe_pixel_if
// Valid/ready channel carrying one raster-order pixel word.
// ----------------------------------------------------------------------------
interface mbpe_pixel_if;
  import mbpe_pkg::*;

  logic              valid;
  logic              ready;
  logic [PixelW-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);

endinterface

// ===== src/mbpe_point_if.sv =====
// ----------------------------------------------------------------------------
// mbpe_point_if
// Valid/ready channel carrying one boundary point or end-of-frame marker.
// ----------------------------------------------------------------------------
interface mbpe_point_if;
  import mbpe_pkg::*;

  logic              valid;
  logic              ready;
  logic [CoordW-1:0] point_x;
  logic [CoordW-1:0] point_y;
  logic              is_point;
  logic              frame_end;

  modport source (output valid, output point_x, output point_y, output is_point,
                  output frame_end, input ready);
  modport sink   (input valid, input point_x, input point_y, input is_point,
                  input frame_end, output ready);

endinterface

// ===== src/mbpe_front.sv =====
// ----------------------------------------------------------------------------
// mbpe_front
// Accepts pixels, holds the size registers and the raster position, and
// classifies the pixel decided by each incoming pixel.
// ----------------------------------------------------------------------------
module mbpe_front #(
  parameter int MAX_WIDTH  = mbpe_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = mbpe_pkg::MaxHeightDefault,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mbpe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mbpe_pkg::CfgDataW-1:0]  cfg_wdata_i,
  mbpe_pixel_if.sink                     pix_in,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output mbpe_pkg::mbpe_cls_t            q_cls_o,
  output logic [AW-1:0]                  q_ci_o,
  output logic [AW-1:0]                  q_ri_o
);
  import mbpe_pkg::*;

  localparam int ResetW = (CfgSizeReset > MAX_WIDTH)  ? MAX_WIDTH  : CfgSizeReset;
  localparam int ResetH = (CfgSizeReset > MAX_HEIGHT) ? MAX_HEIGHT : CfgSizeReset;

  logic [AW-1:0] wm1_q, wm1_d;
  logic [RW-1:0] hm1_q, hm1_d;
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [31:0]   cfg_v;
  logic [31:0]   eff_w;
  logic [31:0]   eff_h;
  logic          accept;
  logic          row_end;
  logic          frame_last;

  assign pix_in.ready = !q_full_i;
  assign accept       = pix_in.valid && pix_in.ready;

  assign row_end    = (col_q == wm1_q);
  assign frame_last = row_end && (row_q == hm1_q);

  // Zero acts as one, oversize saturates to the buffer limit
  always_comb begin
    cfg_v = 32'(cfg_wdata_i);
    if (cfg_v == 32'd0) begin
      eff_w = 32'd1;
      eff_h = 32'd1;
    end else begin
      eff_w = (cfg_v > 32'(MAX_WIDTH))  ? 32'(MAX_WIDTH)  : cfg_v;
      eff_h = (cfg_v > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : cfg_v;
    end
    wm1_d = wm1_q;
    hm1_d = hm1_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgImageWidth:  wm1_d = AW'(eff_w - 32'd1);
        CfgImageHeight: hm1_d = RW'(eff_h - 32'd1);
        default: ;
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (frame_last) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q <= AW'(ResetW - 1);
      hm1_q <= RW'(ResetH - 1);
      col_q <= '0;
      row_q <= '0;
    end else begin
      wm1_q <= wm1_d;
      hm1_q <= hm1_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign q_push_o         = accept;
  assign q_cls_o.below    = (((pix_in.pixel_word >> AlphaShift) & PixelW'(AlphaMask)) != '0);
  assign q_cls_o.interior = (row_q > RW'(1)) && (col_q != '0) && !row_end;
  assign q_cls_o.last     = frame_last;
  assign q_cls_o.px       = CoordW'(32'(col_q));
  assign q_cls_o.py       = CoordW'(32'(row_q) - 32'd1);
  assign q_ci_o           = col_q;
  // Right neighbor address, held at the last buffer entry
  assign q_ri_o           = (col_q == AW'(MAX_WIDTH - 1)) ? col_q : col_q + AW'(1);

endmodule

// ===== src/mbpe_fifo.sv =====
// ----------------------------------------------------------------------------
// mbpe_fifo
// Short register queue between the classifier and the line-buffer stage.
// ----------------------------------------------------------------------------
module mbpe_fifo #(
  parameter int DEPTH = mbpe_pkg::QueueDepth,
  parameter int WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

// ===== src/mbpe_back.sv =====
// ----------------------------------------------------------------------------
// mbpe_back
// Line-buffer stage: reads the mask bits around the decided pixel, updates
// the two-row buffer and registers the resulting point or marker.
// ----------------------------------------------------------------------------
module mbpe_back #(
  parameter int MAX_WIDTH = mbpe_pkg::MaxWidthDefault,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  mbpe_pkg::mbpe_cls_t  q_cls_i,
  input  logic [AW-1:0]        q_ci_i,
  input  logic [AW-1:0]        q_ri_i,
  output logic                 q_pop_o,
  mbpe_point_if.source         pt_out
);
  import mbpe_pkg::*;

  // Entry bit 1: row two above the input, bit 0: row one above the input
  logic [1:0]    mem_q [MAX_WIDTH];
  logic [1:0]    rd_c_q;
  logic [1:0]    rd_r_q;
  mbpe_cls_t     b_cls_q;
  logic [AW-1:0] b_addr_q;
  logic          b_valid_q;
  logic          left_q;
  logic          out_valid_q;
  logic [CoordW-1:0] out_x_q, out_y_q;
  logic          out_pt_q, out_end_q;
  logic          adv;
  logic          center, up, right, point;

  assign adv     = !out_valid_q || pt_out.ready;
  assign q_pop_o = adv && !q_empty_i;

  assign center = rd_c_q[0];
  assign up     = rd_c_q[1];
  assign right  = rd_r_q[0];
  assign point  = b_cls_q.interior && center &&
                  (!left_q || !right || !up || !b_cls_q.below);

  // Write of the leaving pixel and read for the entering one share an edge;
  // their addresses differ whenever the result can matter
  always_ff @(posedge clk_i) begin
    if (adv && b_valid_q) begin
      mem_q[b_addr_q] <= {center, b_cls_q.below};
      left_q          <= center;
    end
    if (q_pop_o) begin
      rd_c_q   <= mem_q[q_ci_i];
      rd_r_q   <= mem_q[q_ri_i];
      b_cls_q  <= q_cls_i;
      b_addr_q <= q_ci_i;
    end
    if (adv) begin
      out_x_q   <= point ? b_cls_q.px : '0;
      out_y_q   <= point ? b_cls_q.py : '0;
      out_pt_q  <= point;
      out_end_q <= !point;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q   <= !q_empty_i;
      out_valid_q <= b_valid_q && (point || b_cls_q.last);
    end
  end

  assign pt_out.valid     = out_valid_q;
  assign pt_out.point_x   = out_x_q;
  assign pt_out.point_y   = out_y_q;
  assign pt_out.is_point  = out_pt_q;
  assign pt_out.frame_end = out_end_q;

`ifndef SYNTHESIS
  a_marker_off_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_cls_q.last |-> !b_cls_q.interior)
    else $error("frame-closing pixel classified as interior");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(b_valid_q))
    else $error("buffer stage moved while output stalled");

  a_point_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && b_valid_q && point |=> out_valid_q && pt_out.is_point && !pt_out.frame_end)
    else $error("boundary point not transferred to output register");
`endif

endmodule

// ===== src/mask_boundary_point_extractor.sv =====
// ----------------------------------------------------------------------------
// mask_boundary_point_extractor
// Four-neighbor boundary extraction on a raster-order alpha mask.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, sustained, while the output side takes results.
// A pixel's alpha byte is reduced to one mask bit; a two-bit-wide line buffer
// of MAX_WIDTH entries holds the two rows above the input and is read at two
// addresses per pixel. Each pixel decides the pixel one row above it: a
// boundary point comes out with its (x, y) when that pixel is set, interior,
// and has a clear left, right, upper or lower neighbor. The last pixel of a
// frame gives an end marker. A result passes the queue, the buffer read
// register and the output register after its deciding pixel is transferred;
// a four-entry queue lets the input keep running while the output stalls,
// until it is full. The line buffer needs no clearing after reset: the first
// two rows of each frame rebuild it. Size register writes restart the frame.
// ----------------------------------------------------------------------------
module mask_boundary_point_extractor #(
  parameter int MAX_WIDTH  = mbpe_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = mbpe_pkg::MaxHeightDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbpe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mbpe_pkg::CfgDataW-1:0] cfg_wdata_i,
  mbpe_pixel_if.sink                    pix_in,
  mbpe_point_if.source                  pt_out
);
  import mbpe_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(mbpe_cls_t) + 2 * AW;

  logic          q_push, q_pop, q_full, q_empty;
  mbpe_cls_t     f_cls, h_cls;
  logic [AW-1:0] f_ci, f_ri, h_ci, h_ri;
  logic [QW-1:0] q_rdata;

  mbpe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_in      (pix_in),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cls_o     (f_cls),
    .q_ci_o      (f_ci),
    .q_ri_o      (f_ri)
  );

  mbpe_fifo #(
    .DEPTH (QueueDepth),
    .WIDTH (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_cls, f_ci, f_ri}),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {h_cls, h_ci, h_ri} = q_rdata;

  mbpe_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cls_i   (h_cls),
    .q_ci_i    (h_ci),
    .q_ri_i    (h_ri),
    .q_pop_o   (q_pop),
    .pt_out    (pt_out)
  );

endmodule
